[rtl/rgb_to_hsi_hue_unit_defines.svh]
// Assertion macros for the rgb_to_hsi_hue_unit RTL.
// Included by the top level; no other dependencies.
`ifndef RGB_TO_HSI_HUE_UNIT_DEFINES_SVH
`define RGB_TO_HSI_HUE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HSI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsi: same-cycle check failed");
`define HSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsi: next-cycle check failed");
`else
`define HSI_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HSI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/hsi_pkg.sv]
// Shared types, constants and the cosine threshold function for the HSI hue unit.
// No dependencies.
package hsi_pkg;

   localparam int CHAN_W    = 8;
   localparam int HUE_W     = 9;
   localparam int FRAC_W    = 16;               // sqrt works on D << (2*FRAC_W)
   localparam int Q_W       = 17;               // quotient bits kept, covers 0..2^17-1
   localparam int Q_SHIFT   = 2 * FRAC_W - Q_W; // dividend pre-shift for first divide cell
   localparam int X_W       = 18;               // signed Q16 ratio
   localparam int DEG_MAX   = 180;
   localparam int THETA_W   = 8;
   localparam int HUE_MAX   = 359;
   localparam int COS_SHIFT = 14;               // Q30 -> Q16

   localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);
   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint COS1_Q30 = 64'sd1073578288;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue_degrees;
      logic             gray_pixel;
   } rsp_type;

   // per-beat flags that ride alongside the datapath
   typedef struct packed {
      logic neg;     // numerator negative
      logic b_gt_g;  // blue above green, hue reflected
      logic gray;
      logic ovf;     // quotient at or above 2^17
   } side_type;

   // floor(cos(d deg) in Q30 / 2^14), cosine from the integer recurrence
   function automatic logic signed [X_W-1:0] cos_thr(input int d);
      longint c_prev;
      longint c_cur;
      longint c_next;
      longint p;
      longint m;
      longint r;
      c_prev = ONE_Q30;
      c_cur  = COS1_Q30;
      for (int k = 1; k < d; k++) begin
         p = COS1_Q30 * c_cur;
         m = (p < 0) ? -p : p;
         r = (m + (longint'(1) <<< 29)) >>> 30;
         if (p < 0) begin
            r = -r;
         end
         c_next = 2 * r - c_prev;
         c_prev = c_cur;
         c_cur  = c_next;
      end
      if (d == 0) begin
         c_cur = ONE_Q30;
      end
      if (d >= DEG_MAX) begin
         c_cur = -ONE_Q30;
      end
      return X_W'(c_cur >>> COS_SHIFT);
   endfunction

endpackage

[rtl/hsi_sqrt_cell.sv]
// One digit cell of the pipelined square root: two radicand bits in, one root bit out.
// Depends on hsi_pkg.
module hsi_sqrt_cell #(
   parameter int RW = 24,
   parameter int MW = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*RW-1:0]     in_rad,
   input  logic [RW:0]         in_rem,
   input  logic [RW-1:0]       in_root,
   input  logic [MW-1:0]       in_mag,
   input  hsi_pkg::side_type   in_side,
   output logic                out_valid,
   output logic [2*RW-1:0]     out_rad,
   output logic [RW:0]         out_rem,
   output logic [RW-1:0]       out_root,
   output logic [MW-1:0]       out_mag,
   output hsi_pkg::side_type   out_side
);

   logic                valid_ff;
   logic [2*RW-1:0]     rad_ff;
   logic [RW:0]         rem_ff, rem_in;
   logic [RW-1:0]       root_ff, root_in;
   logic [MW-1:0]       mag_ff;
   hsi_pkg::side_type   side_ff;
   logic [RW+2:0]       rem_sh;
   logic [RW+2:0]       trial;
   logic                ge;

   always_comb begin
      rem_sh  = {in_rem, in_rad[2*RW-1 -: 2]};
      trial   = {1'b0, in_root, 2'b01};
      ge      = rem_sh >= trial;
      rem_in  = ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
      root_in = {in_root[RW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= {in_rad[2*RW-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         mag_ff  <= in_mag;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_mag   = mag_ff;
   assign out_side  = side_ff;

endmodule

[rtl/hsi_div_cell.sv]
// One restoring-division cell: one quotient bit per cell.
// Depends on hsi_pkg.
module hsi_div_cell #(
   parameter int DW = 25
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [DW-1:0]            in_rem,
   input  logic [DW-1:0]            in_dv,
   input  logic [hsi_pkg::Q_W-1:0]  in_q,
   input  hsi_pkg::side_type        in_side,
   output logic                     out_valid,
   output logic [DW-1:0]            out_rem,
   output logic [DW-1:0]            out_dv,
   output logic [hsi_pkg::Q_W-1:0]  out_q,
   output hsi_pkg::side_type        out_side
);

   logic                     valid_ff;
   logic [DW-1:0]            rem_ff, rem_in;
   logic [DW-1:0]            dv_ff;
   logic [hsi_pkg::Q_W-1:0]  q_ff, q_in;
   hsi_pkg::side_type        side_ff;
   logic [DW:0]              rem_sh;
   logic                     ge;

   always_comb begin
      rem_sh = {in_rem, 1'b0};
      ge     = rem_sh >= {1'b0, in_dv};
      rem_in = ge ? DW'(rem_sh - {1'b0, in_dv}) : DW'(rem_sh);
      q_in   = {in_q[hsi_pkg::Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         dv_ff   <= in_dv;
         q_ff    <= q_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dv    = dv_ff;
   assign out_q     = q_ff;
   assign out_side  = side_ff;

endmodule

[rtl/hsi_hue_lut.sv]
// Angle lookup: compares the Q16 cosine against the constant degree thresholds,
// registers the thermometer code and encodes it to whole degrees. Depends on hsi_pkg.
module hsi_hue_lut (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [hsi_pkg::X_W-1:0] in_x,
   input  hsi_pkg::side_type             in_side,
   output logic                          out_valid,
   output hsi_pkg::side_type             out_side,
   output logic [hsi_pkg::THETA_W-1:0]   out_theta
);

   logic                            valid_ff;
   hsi_pkg::side_type               side_ff;
   logic [hsi_pkg::DEG_MAX-1:0]     therm_ff, therm_in;
   logic [hsi_pkg::DEG_MAX-1:0]     edge_bit;
   logic [hsi_pkg::THETA_W-1:0]     theta;

   // bit i set when cos((i+1) deg) >= x; cosine falls, so the set bits form a prefix
   always_comb begin
      for (int i = 0; i < hsi_pkg::DEG_MAX; i++) begin
         therm_in[i] = in_x <= hsi_pkg::cos_thr(i + 1);
      end
   end

   always_comb begin
      theta = '0;
      for (int i = 0; i < hsi_pkg::DEG_MAX; i++) begin
         if (i == hsi_pkg::DEG_MAX - 1) begin
            edge_bit[i] = therm_ff[i];
         end else begin
            edge_bit[i] = therm_ff[i] & ~therm_ff[i+1];
         end
         if (edge_bit[i]) begin
            theta = theta | hsi_pkg::THETA_W'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         therm_ff <= therm_in;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_theta = theta;

endmodule

[rtl/rgb_to_hsi_hue_unit.sv]
// Top level of the HSI hue unit: input register, D and numerator stage, square-root
// and divide cell chains, angle lookup and result register. Depends on hsi_pkg, the
// cell modules and rgb_to_hsi_hue_unit_defines.svh.
//
// Usage: one pixel beat on req_ (valid/ready) gives one result beat on rsp_, in order.
// rsp_result.hue_degrees is the HSI hue in whole degrees (0..359); for a gray pixel
// it is 0 and rsp_result.gray_pixel is set.
// Throughput: one pixel per cycle while the result register is empty or being taken. The
// square-root chain has one cell per root bit (PIXEL_BITS + 16 cells) and the divide
// chain has 17 cells.
// The whole pipeline advances together whenever the result register is empty or
// being taken; while rsp_valid is high and rsp_ready low, every stage holds and
// req_ready is low. Pipeline bubbles still move forward.
// Reset clears every stage's valid bit; no result is pending afterward.
`include "rgb_to_hsi_hue_unit_defines.svh"
module rgb_to_hsi_hue_unit #(
   parameter int PIXEL_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hsi_pkg::req_type  req_pixel,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hsi_pkg::rsp_type  rsp_result
);

   localparam int P   = PIXEL_BITS;
   localparam int RW  = P + hsi_pkg::FRAC_W;
   localparam int MW  = P + 1;
   localparam int DW  = RW + 1;
   localparam int QW  = hsi_pkg::Q_W;

   logic en;

   // input register
   logic         in_valid_ff;
   logic [P-1:0] red_ff, green_ff, blue_ff;
   logic [15:0]  red_w, green_w, blue_w;

   assign red_w   = 16'(req_pixel.red);
   assign green_w = 16'(req_pixel.green);
   assign blue_w  = 16'(req_pixel.blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff   <= red_w[P-1:0];
         green_ff <= green_w[P-1:0];
         blue_ff  <= blue_w[P-1:0];
      end
   end

   // D = (R-G)^2 + (R-B)(G-B), numerator 2R-G-B
   logic signed [P:0]     d_rg, d_rb, d_gb;
   logic signed [2*P+1:0] prod_a, prod_b;
   logic signed [2*P+2:0] dsum;
   logic signed [P+1:0]   num;
   logic [MW-1:0]         mag;
   hsi_pkg::side_type     prep_side;

   always_comb begin
      d_rg   = $signed({1'b0, red_ff}) - $signed({1'b0, green_ff});
      d_rb   = $signed({1'b0, red_ff}) - $signed({1'b0, blue_ff});
      d_gb   = $signed({1'b0, green_ff}) - $signed({1'b0, blue_ff});
      prod_a = d_rg * d_rg;
      prod_b = d_rb * d_gb;
      dsum   = (2*P+3)'(prod_a) + (2*P+3)'(prod_b);
      num    = $signed({1'b0, red_ff, 1'b0}) - $signed({2'b00, green_ff})
               - $signed({2'b00, blue_ff});
      mag    = num[P+1] ? MW'(-num) : MW'(num);
      prep_side.neg    = num[P+1];
      prep_side.b_gt_g = blue_ff > green_ff;
      prep_side.gray   = (red_ff == green_ff) && (green_ff == blue_ff);
      prep_side.ovf    = 1'b0;
   end

   // square-root chain
   logic                    sq_valid [RW+1];
   logic [2*RW-1:0]         sq_rad   [RW+1];
   logic [RW:0]             sq_rem   [RW+1];
   logic [RW-1:0]           sq_root  [RW+1];
   logic [MW-1:0]           sq_mag   [RW+1];
   hsi_pkg::side_type       sq_side  [RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid[0] <= 1'b0;
      end else if (en) begin
         sq_valid[0] <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_rad[0]  <= {dsum[2*P-1:0], {(2*hsi_pkg::FRAC_W){1'b0}}};
         sq_rem[0]  <= '0;
         sq_root[0] <= '0;
         sq_mag[0]  <= mag;
         sq_side[0] <= prep_side;
      end
   end

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      hsi_sqrt_cell #(.RW(RW), .MW(MW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[i]),
         .in_rad    (sq_rad[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_mag    (sq_mag[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_valid[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_mag   (sq_mag[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   // divide setup: divisor 2*sqrt, first partial remainder mag << 15
   logic [DW-1:0]       setup_dv, setup_rem;
   hsi_pkg::side_type   setup_side;

   always_comb begin
      setup_dv        = {sq_root[RW], 1'b0};
      setup_rem       = DW'({sq_mag[RW], {hsi_pkg::Q_SHIFT{1'b0}}});
      setup_side      = sq_side[RW];
      setup_side.ovf  = setup_rem >= setup_dv;
   end

   logic                dv_valid [QW+1];
   logic [DW-1:0]       dv_rem   [QW+1];
   logic [DW-1:0]       dv_div   [QW+1];
   logic [QW-1:0]       dv_q     [QW+1];
   hsi_pkg::side_type   dv_side  [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid[0] <= 1'b0;
      end else if (en) begin
         dv_valid[0] <= sq_valid[RW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem[0]  <= setup_rem;
         dv_div[0]  <= setup_dv;
         dv_q[0]    <= '0;
         dv_side[0] <= setup_side;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      hsi_div_cell #(.DW(DW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[j]),
         .in_rem    (dv_rem[j]),
         .in_dv     (dv_div[j]),
         .in_q      (dv_q[j]),
         .in_side   (dv_side[j]),
         .out_valid (dv_valid[j+1]),
         .out_rem   (dv_rem[j+1]),
         .out_dv    (dv_div[j+1]),
         .out_q     (dv_q[j+1]),
         .out_side  (dv_side[j+1])
      );
   end

   // clamp to one and apply the sign
   logic [QW-1:0]                    q_clamp;
   logic signed [hsi_pkg::X_W-1:0]   x_q16;

   always_comb begin
      if (dv_side[QW].ovf || (dv_q[QW] > hsi_pkg::ONE_Q16)) begin
         q_clamp = hsi_pkg::ONE_Q16;
      end else begin
         q_clamp = dv_q[QW];
      end
      if (dv_side[QW].neg) begin
         x_q16 = -$signed({1'b0, q_clamp});
      end else begin
         x_q16 = $signed({1'b0, q_clamp});
      end
   end

   logic                           lut_valid;
   hsi_pkg::side_type              lut_side;
   logic [hsi_pkg::THETA_W-1:0]    lut_theta;

   hsi_hue_lut u_lut (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid[QW]),
      .in_x      (x_q16),
      .in_side   (dv_side[QW]),
      .out_valid (lut_valid),
      .out_side  (lut_side),
      .out_theta (lut_theta)
   );

   // result register
   logic              rsp_valid_ff;
   hsi_pkg::rsp_type  rsp_ff, rsp_in;

   always_comb begin
      rsp_in.gray_pixel = lut_side.gray;
      if (lut_side.gray) begin
         rsp_in.hue_degrees = '0;
      end else if (lut_side.b_gt_g) begin
         rsp_in.hue_degrees = hsi_pkg::HUE_W'(hsi_pkg::HUE_MAX)
                              - hsi_pkg::HUE_W'(lut_theta);
      end else begin
         rsp_in.hue_degrees = hsi_pkg::HUE_W'(lut_theta);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lut_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign en         = !rsp_valid_ff || rsp_ready;
   assign req_ready  = en;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   `HSI_ASSERT_NOW(a_gray_hue_zero, clock, reset, rsp_valid && rsp_result.gray_pixel, rsp_result.hue_degrees == '0)
   `HSI_ASSERT_NOW(a_hue_in_range, clock, reset, rsp_valid, rsp_result.hue_degrees <= hsi_pkg::HUE_W'(hsi_pkg::HUE_MAX))
   `HSI_ASSERT_NOW(a_no_take_in_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `HSI_ASSERT_NEXT(a_lut_to_rsp, clock, reset, lut_valid && en, rsp_valid)

endmodule
